// File: rtl/ydc_pkg.sv
package ydc_pkg;

	// Index and count width, covers up to 511 entries
	localparam int IDX_W = 9;
	// Signed width of a stored row or column
	localparam int DAT_W = 12;
	localparam int RANK_W = 15;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_DEL  = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [2:0] ST_OK    = 3'd0;
	localparam logic [2:0] ST_BAD   = 3'd1;
	localparam logic [2:0] ST_ZERO  = 3'd2;
	localparam logic [2:0] ST_FULL  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE, S_BUILD, S_SCAN, S_EDIT1, S_EDIT2, S_RANK, S_RESP
	} ydc_state_t;

	typedef enum logic [1:0] {P_HOLD, P_INS, P_SHIFT} part_op_t;
	typedef enum logic [2:0] {C_HOLD, C_PUT, C_INS, C_DEL, C_ROT} cor_op_t;

	typedef struct packed {
		logic [IDX_W-1:0]        p;
		logic signed [DAT_W-1:0] r;
		logic signed [DAT_W-1:0] c;
	} cell_data_t;

	typedef struct packed {
		part_op_t                part_op;
		cor_op_t                 cor_op;
		logic [IDX_W-1:0]        pos;
		logic [IDX_W-1:0]        cnt;
		logic [IDX_W-1:0]        part;
		logic signed [DAT_W-1:0] row;
		logic signed [DAT_W-1:0] col;
	} cell_ctl_t;

endpackage

// File: rtl/ydc_if.sv
interface ydc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [6:0] value;
	logic       last;
	modport source (output valid, output op, output value, output last, input ready);
	modport sink (input valid, input op, input value, input last, output ready);
endinterface

interface ydc_out_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic [6:0]         corner_count;
	logic signed [14:0] rank_value;
	logic [6:0]         corner_row;
	logic [6:0]         corner_col;
	modport source (output valid, output status, output corner_count, output rank_value,
		output corner_row, output corner_col, input ready);
	modport sink (input valid, input status, input corner_count, input rank_value,
		input corner_row, input corner_col, output ready);
endinterface

// File: rtl/ydc_cell.sv
module ydc_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  ydc_pkg::cell_ctl_t  ctl,
	input  ydc_pkg::cell_data_t prv,
	input  ydc_pkg::cell_data_t nxt,
	input  ydc_pkg::cell_data_t head,
	output ydc_pkg::cell_data_t cur
);

	localparam logic [ydc_pkg::IDX_W-1:0] MY_IDX = ydc_pkg::IDX_W'(IDX);

	logic [ydc_pkg::IDX_W-1:0]        p_q;
	logic signed [ydc_pkg::DAT_W-1:0] r_q, c_q;
	logic own_ge, prv_ge;

	assign cur = {p_q, r_q, c_q};
	assign own_ge = p_q >= ctl.part;
	assign prv_ge = (IDX == 0) ? 1'b1 : (prv.p >= ctl.part);

	// Part buffer: sorted insertion or advance toward the head
	always_ff @(posedge clk) begin
		case (ctl.part_op)
			ydc_pkg::P_INS: begin
				if ((MY_IDX < ctl.cnt && !own_ge) || MY_IDX == ctl.cnt) begin
					p_q <= prv_ge ? ctl.part : prv.p;
				end
			end
			ydc_pkg::P_SHIFT: p_q <= nxt.p;
			default: ;
		endcase
	end

	// Corner entry: write, open a slot, close a slot or rotate
	always_ff @(posedge clk) begin
		case (ctl.cor_op)
			ydc_pkg::C_PUT: begin
				if (MY_IDX == ctl.pos) begin
					r_q <= ctl.row;
					c_q <= ctl.col;
				end
			end
			ydc_pkg::C_INS: begin
				if (MY_IDX == ctl.pos) begin
					r_q <= ctl.row;
					c_q <= ctl.col;
				end else if (MY_IDX > ctl.pos) begin
					r_q <= prv.r;
					c_q <= prv.c;
				end
			end
			ydc_pkg::C_DEL: begin
				if (MY_IDX >= ctl.pos) begin
					r_q <= nxt.r;
					c_q <= nxt.c;
				end
			end
			ydc_pkg::C_ROT: begin
				if (MY_IDX == ctl.cnt) begin
					r_q <= head.r;
					c_q <= head.c;
				end else begin
					r_q <= nxt.r;
					c_q <= nxt.c;
				end
			end
			default: ;
		endcase
	end

endmodule

// File: rtl/young_diagram_corner_removal.sv
// Removable corners of a Young diagram, kept in a row of cells.
// req carries one transaction per item (op, value, last); rsp returns exactly
// one result per item (status, corner count, rank value, read corner).
// Items are handled one at a time. Every item ends with a rank pass over the
// corners and the response state; a load with last first builds the corners
// from the parts, and a valid delete first scans the corners and then edits
// the list in the EDIT1 and EDIT2 states.
// The rank sum rotates the corner list through the head cell once, one
// corner per cycle, and a delete rotates it once more to fetch neighbors.
// Parts insert in sorted order, in parallel across all cells, on acceptance.
// The result sits in an output register; req is ready again as soon as the
// result is registered, even while rsp stalls, but the following result
// waits until the held one is taken.
// Reset empties the part buffer and the corner list and drops any pending
// result; stored cell contents are left as they are.
module young_diagram_corner_removal #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	ydc_in_if.sink     req,
	ydc_out_if.source  rsp
);

	localparam int IW = ydc_pkg::IDX_W;
	localparam int DW = ydc_pkg::DAT_W;
	localparam int RW = ydc_pkg::RANK_W;
	localparam logic [IW-1:0] MAXR = IW'(MAX_ROWS);
	localparam logic [IW-1:0] MAXC = IW'(MAX_COLS);

	ydc_pkg::ydc_state_t state_q, state_d;
	ydc_pkg::cell_ctl_t  ctl;
	ydc_pkg::cell_data_t cd [MAX_ROWS];
	ydc_pkg::cell_data_t head, nxt1, zero_d;

	logic [IW-1:0] pt_q, ct_q, k_q, idx_q;
	logic [1:0]    op_q;
	logic [2:0]    status_q;
	logic signed [DW-1:0] r_q, c_q, pr_q, nc_q, prow_q;
	logic signed [DW-1:0] rd_row_q, rd_col_q;
	logic signed [RW-1:0] acc_q;
	logic          a2_q;
	logic [IW-1:0] a2_pos_q;
	logic signed [DW-1:0] a2_row_q, a2_col_q;

	logic          o_valid_q;
	logic [2:0]    o_status_q;
	logic [6:0]    o_count_q, o_row_q, o_col_q;
	logic signed [14:0] o_rank_q;

	logic          acc_in, stored;
	logic [IW-1:0] val_w, part_v, pt_new;
	logic          build_put;
	logic signed [RW-1:0] fac, prod;

	// Edit decision
	ydc_pkg::cor_op_t     e1_op;
	logic signed [DW-1:0] e1_row, e1_col;
	logic                 e2_en;
	logic [IW-1:0]        e2_pos;
	logic signed [DW-1:0] e2_row, e2_col;
	logic signed [DW-1:0] rm1, cm1;

	assign zero_d = '0;
	assign head = cd[0];
	assign nxt1 = (MAX_ROWS > 1) ? cd[(MAX_ROWS > 1) ? 1 : 0] : zero_d;

	// Cell row
	for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
		ydc_cell #(.IDX(g)) u_cell (
			.clk (clk),
			.ctl (ctl),
			.prv ((g == 0) ? zero_d : cd[(g == 0) ? 0 : g - 1]),
			.nxt ((g == MAX_ROWS - 1) ? zero_d : cd[(g == MAX_ROWS - 1) ? g : g + 1]),
			.head(head),
			.cur (cd[g])
		);
	end

	assign req.ready = state_q == ydc_pkg::S_IDLE;
	assign acc_in = req.valid && req.ready;
	assign val_w = IW'(req.value);
	assign part_v = (val_w > MAXC) ? MAXC : val_w;
	assign stored = req.value != '0 && pt_q < MAXR;
	assign pt_new = stored ? pt_q + 1'b1 : pt_q;
	assign build_put = (k_q == pt_q - 1'b1) || (head.p > nxt1.p);

	// Rank term of the corner at the head
	assign fac = (k_q == '0) ? RW'(head.r) : RW'(prow_q - head.r);
	assign prod = RW'(fac * RW'(head.c));

	// Case rules for removing the box at a corner
	assign rm1 = r_q - 1'b1;
	assign cm1 = c_q - 1'b1;
	always_comb begin
		e1_op = ydc_pkg::C_HOLD;
		e1_row = r_q;
		e1_col = c_q;
		e2_en = 1'b0;
		e2_pos = idx_q;
		e2_row = r_q;
		e2_col = cm1;
		if (ct_q == IW'(1)) begin
			if (r_q == 1 && c_q == 1) begin
				e1_op = ydc_pkg::C_DEL;
			end else if (r_q == 1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_col = cm1;
			end else if (c_q == 1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_row = rm1;
			end else begin
				e1_op = ydc_pkg::C_PUT;
				e1_row = rm1;
				e2_en = 1'b1;
				e2_pos = ct_q;
			end
		end else if (idx_q == '0) begin
			if (r_q == 1 && nc_q == cm1) begin
				e1_op = ydc_pkg::C_DEL;
			end else if (r_q == 1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_col = cm1;
			end else if (nc_q == cm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_row = rm1;
			end else begin
				e1_op = ydc_pkg::C_PUT;
				e1_col = cm1;
				e2_en = 1'b1;
				e2_pos = '0;
				e2_row = rm1;
				e2_col = c_q;
			end
		end else if (idx_q == ct_q - 1'b1) begin
			if (c_q == 1 && pr_q < rm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_row = rm1;
			end else if (c_q == 1 && pr_q == rm1) begin
				e1_op = ydc_pkg::C_DEL;
			end else if (c_q > 1 && pr_q == rm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_col = cm1;
			end else if (c_q > 1 && pr_q < rm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_row = rm1;
				e2_en = 1'b1;
				e2_pos = ct_q;
			end
		end else begin
			if (pr_q == rm1 && nc_q < cm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_col = cm1;
			end else if (pr_q < rm1 && nc_q < cm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_col = cm1;
				e2_en = 1'b1;
				e2_row = rm1;
				e2_col = c_q;
			end else if (pr_q < rm1) begin
				e1_op = ydc_pkg::C_PUT;
				e1_row = rm1;
			end else if (nc_q == cm1) begin
				e1_op = ydc_pkg::C_DEL;
			end
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ydc_pkg::S_IDLE: begin
				if (acc_in) begin
					state_d = ydc_pkg::S_RANK;
					if (req.op == ydc_pkg::OP_LOAD && req.last && pt_new != '0) begin
						state_d = ydc_pkg::S_BUILD;
					end else if (req.op == ydc_pkg::OP_DEL && val_w < ct_q) begin
						state_d = ydc_pkg::S_SCAN;
					end
				end
			end
			ydc_pkg::S_BUILD: if (k_q == pt_q - 1'b1) state_d = ydc_pkg::S_RANK;
			ydc_pkg::S_SCAN:  if (k_q == ct_q - 1'b1) state_d = ydc_pkg::S_EDIT1;
			ydc_pkg::S_EDIT1: state_d = ydc_pkg::S_EDIT2;
			ydc_pkg::S_EDIT2: state_d = ydc_pkg::S_RANK;
			ydc_pkg::S_RANK: begin
				if (ct_q == '0 || k_q == ct_q - 1'b1) state_d = ydc_pkg::S_RESP;
			end
			ydc_pkg::S_RESP: if (!o_valid_q || rsp.ready) state_d = ydc_pkg::S_IDLE;
			default: state_d = ydc_pkg::S_IDLE;
		endcase
	end

	// Cell commands
	always_comb begin
		ctl = '0;
		ctl.part_op = ydc_pkg::P_HOLD;
		ctl.cor_op = ydc_pkg::C_HOLD;
		ctl.part = part_v;
		ctl.cnt = ct_q - 1'b1;
		unique case (state_q)
			ydc_pkg::S_IDLE: begin
				if (acc_in && req.op == ydc_pkg::OP_LOAD && stored) begin
					ctl.part_op = ydc_pkg::P_INS;
					ctl.cnt = pt_q;
				end
			end
			ydc_pkg::S_BUILD: begin
				ctl.part_op = ydc_pkg::P_SHIFT;
				if (build_put) begin
					ctl.cor_op = ydc_pkg::C_PUT;
					ctl.pos = ct_q;
					ctl.row = DW'(k_q) + 1'b1;
					ctl.col = DW'(head.p);
				end
			end
			ydc_pkg::S_SCAN, ydc_pkg::S_RANK: begin
				if (ct_q != '0) ctl.cor_op = ydc_pkg::C_ROT;
			end
			ydc_pkg::S_EDIT1: begin
				ctl.cor_op = e1_op;
				ctl.pos = idx_q;
				ctl.row = e1_row;
				ctl.col = e1_col;
			end
			ydc_pkg::S_EDIT2: begin
				if (a2_q && ct_q < MAXR) begin
					ctl.cor_op = ydc_pkg::C_INS;
					ctl.pos = a2_pos_q;
					ctl.row = a2_row_q;
					ctl.col = a2_col_q;
				end
			end
			default: ;
		endcase
	end

	// Control state: counts, step, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ydc_pkg::S_IDLE;
			pt_q <= '0;
			ct_q <= '0;
			k_q <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Present a finished result, else drop the one taken
			if (state_q == ydc_pkg::S_RESP && state_d == ydc_pkg::S_IDLE) begin
				o_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				o_valid_q <= 1'b0;
			end
			case (state_q)
				ydc_pkg::S_IDLE: begin
					k_q <= '0;
					if (acc_in && req.op == ydc_pkg::OP_LOAD) begin
						pt_q <= pt_new;
						if (req.last && pt_new != '0) ct_q <= '0;
					end
				end
				ydc_pkg::S_BUILD: begin
					if (build_put) ct_q <= ct_q + 1'b1;
					if (k_q == pt_q - 1'b1) begin
						pt_q <= '0;
						k_q <= '0;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				ydc_pkg::S_SCAN: k_q <= (k_q == ct_q - 1'b1) ? '0 : k_q + 1'b1;
				ydc_pkg::S_EDIT1: if (e1_op == ydc_pkg::C_DEL) ct_q <= ct_q - 1'b1;
				ydc_pkg::S_EDIT2: if (a2_q && ct_q < MAXR) ct_q <= ct_q + 1'b1;
				ydc_pkg::S_RANK: k_q <= k_q + 1'b1;
				default: ;
			endcase
		end
	end

	// Item registers, captures, rank sum and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ydc_pkg::S_IDLE: begin
				if (acc_in) begin
					op_q <= req.op;
					idx_q <= val_w;
					rd_row_q <= '0;
					rd_col_q <= '0;
					status_q <= ydc_pkg::ST_OK;
					if (req.op == ydc_pkg::OP_LOAD) begin
						if (req.value == '0) status_q <= ydc_pkg::ST_ZERO;
						else if (pt_q >= MAXR) status_q <= ydc_pkg::ST_FULL;
						if (req.last && pt_new == '0) status_q <= ydc_pkg::ST_EMPTY;
					end else if (req.op == ydc_pkg::OP_DEL || req.op == ydc_pkg::OP_READ) begin
						if (val_w >= ct_q) status_q <= ydc_pkg::ST_BAD;
					end
				end
			end
			ydc_pkg::S_SCAN: begin
				if (k_q == idx_q) begin
					r_q <= head.r;
					c_q <= head.c;
				end
				if (idx_q != '0 && k_q == idx_q - 1'b1) pr_q <= head.r;
				if (k_q == idx_q + 1'b1) nc_q <= head.c;
			end
			ydc_pkg::S_EDIT1: begin
				a2_q <= e2_en;
				a2_pos_q <= e2_pos;
				a2_row_q <= e2_row;
				a2_col_q <= e2_col;
			end
			ydc_pkg::S_RANK: begin
				if (ct_q == '0) begin
					acc_q <= RW'(1);
				end else begin
					acc_q <= (k_q == '0) ? prod : acc_q + prod;
					prow_q <= head.r;
					if (op_q == ydc_pkg::OP_READ && status_q == ydc_pkg::ST_OK
						&& k_q == idx_q) begin
						rd_row_q <= head.r;
						rd_col_q <= head.c;
					end
				end
			end
			ydc_pkg::S_RESP: begin
				if (state_d == ydc_pkg::S_IDLE) begin
					o_status_q <= status_q;
					o_count_q <= ct_q[6:0];
					o_rank_q <= acc_q[14:0];
					o_row_q <= rd_row_q[6:0];
					o_col_q <= rd_col_q[6:0];
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid = o_valid_q;
	assign rsp.status = o_status_q;
	assign rsp.corner_count = o_count_q;
	assign rsp.rank_value = o_rank_q;
	assign rsp.corner_row = o_row_q;
	assign rsp.corner_col = o_col_q;

	a_ct_bound: assert property (@(posedge clk) disable iff (!arst_n) ct_q <= MAXR)
		else $error("corner count exceeds capacity");
	a_pt_bound: assert property (@(posedge clk) disable iff (!arst_n) pt_q <= MAXR)
		else $error("part count exceeds capacity");
	a_build_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ydc_pkg::S_BUILD |-> pt_q != '0)
		else $error("corner build with empty part buffer");
	a_resp_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ydc_pkg::S_RESP && state_d == ydc_pkg::S_IDLE) |=> o_valid_q)
		else $error("result not presented after completion");

endmodule

// File: verif/tb_young_diagram_corner_removal.sv
`timescale 1ns / 100ps

module tb_young_diagram_corner_removal;

	localparam int ROWS = 64;
	localparam int COLS = 64;
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 300;

	typedef struct {
		logic [2:0]  status;
		logic [6:0]  count;
		logic [14:0] rank;
		logic [6:0]  row;
		logic [6:0]  col;
	} corner_result_t;

	logic clk;
	logic arst_n;
	ydc_in_if  req();
	ydc_out_if rsp();

	young_diagram_corner_removal #(.MAX_ROWS(ROWS), .MAX_COLS(COLS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp)
	);

	// Shadow diagram state
	int corner_r[ROWS];
	int corner_c[ROWS];
	int corner_n;
	int part_q[ROWS];
	int part_n;

	corner_result_t pending_results[$];
	int error_count;
	int items_sent;
	int results_seen;
	int builds_done;
	int deletes_done;
	bit steady;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what, got,
			want);
		error_count++;
	endtask

	function automatic void put_at(int pos, int r, int c);
		if (pos < ROWS) begin
			corner_r[pos] = r;
			corner_c[pos] = c;
		end
	endfunction

	function automatic void insert_at(int pos, int r, int c);
		if (corner_n >= ROWS || pos > corner_n)
			return;
		for (int k = corner_n; k > pos; k--) begin
			corner_r[k] = corner_r[k-1];
			corner_c[k] = corner_c[k-1];
		end
		corner_r[pos] = r;
		corner_c[pos] = c;
		corner_n++;
	endfunction

	function automatic void remove_at(int pos);
		if (pos >= corner_n)
			return;
		for (int k = pos; k + 1 < corner_n; k++) begin
			corner_r[k] = corner_r[k+1];
			corner_c[k] = corner_c[k+1];
		end
		corner_n--;
	endfunction

	function automatic int diagram_rank();
		int acc;
		if (corner_n == 0)
			return 1;
		acc = corner_r[0] * corner_c[0];
		for (int i = 1; i < corner_n; i++)
			acc += (corner_r[i-1] - corner_r[i]) * corner_c[i];
		return acc;
	endfunction

	function automatic void build_from_parts();
		int n;
		n = part_n;
		corner_n = 0;
		for (int i = 0; i + 1 < n; i++)
			if (part_q[i] > part_q[i+1])
				insert_at(corner_n, i + 1, part_q[i]);
		insert_at(corner_n, n, part_q[n-1]);
		part_n = 0;
		builds_done++;
	endfunction

	// Remove the box at one corner and repair its neighbors
	function automatic void remove_box(int idx);
		int n, r, c, pr, nc;
		n = corner_n;
		r = corner_r[idx];
		c = corner_c[idx];
		deletes_done++;
		if (n == 1) begin
			if (r == 1 && c == 1) remove_at(idx);
			else if (r == 1) put_at(idx, r, c - 1);
			else if (c == 1) put_at(idx, r - 1, c);
			else begin
				put_at(idx, r - 1, c);
				insert_at(corner_n, r, c - 1);
			end
		end else if (idx == 0) begin
			nc = corner_c[1];
			if (r == 1 && nc == c - 1) remove_at(idx);
			else if (r == 1) put_at(idx, r, c - 1);
			else if (nc == c - 1) put_at(idx, r - 1, c);
			else begin
				put_at(idx, r, c - 1);
				insert_at(idx, r - 1, c);
			end
		end else if (idx == n - 1) begin
			pr = corner_r[idx-1];
			if (c == 1 && pr < r - 1) put_at(idx, r - 1, c);
			else if (c == 1 && pr == r - 1) remove_at(idx);
			else if (c > 1 && pr == r - 1) put_at(idx, r, c - 1);
			else if (c > 1 && pr < r - 1) begin
				put_at(idx, r - 1, c);
				insert_at(corner_n, r, c - 1);
			end
		end else begin
			pr = corner_r[idx-1];
			nc = corner_c[idx+1];
			if (pr == r - 1 && nc < c - 1) put_at(idx, r, c - 1);
			else if (pr < r - 1 && nc < c - 1) begin
				put_at(idx, r, c - 1);
				insert_at(idx, r - 1, c);
			end else if (pr < r - 1) put_at(idx, r - 1, c);
			else if (nc == c - 1) remove_at(idx);
		end
	endfunction

	function automatic corner_result_t predict_corners(logic [1:0] op, logic [6:0] value,
			logic last);
		corner_result_t res;
		int v, pos;
		res.status = ydc_pkg::ST_OK;
		res.row = '0;
		res.col = '0;
		case (op)
			ydc_pkg::OP_LOAD: begin
				if (value == 0) res.status = ydc_pkg::ST_ZERO;
				else if (part_n >= ROWS) res.status = ydc_pkg::ST_FULL;
				else begin
					v = (value > COLS) ? COLS : value;
					pos = 0;
					while (pos < part_n && part_q[pos] >= v)
						pos++;
					for (int k = part_n; k > pos; k--)
						part_q[k] = part_q[k-1];
					part_q[pos] = v;
					part_n++;
				end
				if (last) begin
					if (part_n == 0) res.status = ydc_pkg::ST_EMPTY;
					else build_from_parts();
				end
			end
			ydc_pkg::OP_DEL: begin
				if (value >= corner_n) res.status = ydc_pkg::ST_BAD;
				else remove_box(value);
			end
			ydc_pkg::OP_READ: begin
				if (value >= corner_n) res.status = ydc_pkg::ST_BAD;
				else begin
					res.row = corner_r[value];
					res.col = corner_c[value];
				end
			end
			default: ;
		endcase
		res.count = corner_n;
		res.rank = diagram_rank();
		return res;
	endfunction

	task automatic sender_gap();
		while (!steady && $urandom_range(99) < 24) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Drive one transaction and record its expected result on acceptance
	task automatic send_item(input logic [1:0] op, input logic [6:0] value, input logic last);
		sender_gap();
		req.valid <= 1'b1;
		req.op    <= op;
		req.value <= value;
		req.last  <= last;
		do @(posedge clk); while (!req.ready);
		pending_results.push_back(predict_corners(op, value, last));
		items_sent++;
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_parts(input int parts[$]);
		foreach (parts[i])
			send_item(ydc_pkg::OP_LOAD, 7'(parts[i]), i == parts.size() - 1);
	endtask

	// Hold ready low at random, except in the steady stretch
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= steady || ($urandom_range(99) >= 24);
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		corner_result_t want;
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result, queue depth", 0, 0);
			end else begin
				want = pending_results.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", rsp.status, want.status);
				if (rsp.corner_count !== want.count)
					report_mismatch("corner_count", rsp.corner_count, want.count);
				if (rsp.rank_value !== want.rank)
					report_mismatch("rank_value", rsp.rank_value, want.rank);
				if (rsp.corner_row !== want.row)
					report_mismatch("corner_row", rsp.corner_row, want.row);
				if (rsp.corner_col !== want.col)
					report_mismatch("corner_col", rsp.corner_col, want.col);
			end
			results_seen++;
		end
	end

	task automatic test_load_rules();
		send_item(ydc_pkg::OP_LOAD, 7'd1, 1'b1);
		send_item(ydc_pkg::OP_LOAD, 7'd0, 1'b1);
		send_item(ydc_pkg::OP_LOAD, 7'd3, 1'b0);
		send_item(ydc_pkg::OP_LOAD, 7'd127, 1'b0);
		send_item(ydc_pkg::OP_LOAD, 7'd64, 1'b0);
		send_item(ydc_pkg::OP_LOAD, 7'd0, 1'b1);
		send_item(ydc_pkg::OP_LOAD, 7'd65, 1'b0);
		send_item(ydc_pkg::OP_LOAD, 7'd5, 1'b1);
	endtask

	task automatic test_buffer_full();
		for (int i = 0; i < ROWS; i++)
			send_item(ydc_pkg::OP_LOAD, 7'($urandom_range(1, 80)), 1'b0);
		send_item(ydc_pkg::OP_LOAD, 7'd9, 1'b0);
		send_item(ydc_pkg::OP_LOAD, 7'd2, 1'b1);
		send_item(ydc_pkg::OP_READ, 7'd0, 1'b0);
	endtask

	task automatic test_bad_index_and_unused();
		send_item(ydc_pkg::OP_READ, 7'd127, 1'b0);
		send_item(ydc_pkg::OP_DEL, 7'd64, 1'b0);
		send_item(OP_NONE, 7'd127, 1'b1);
		send_item(OP_NONE, 7'd0, 1'b0);
	endtask

	task automatic test_corner_rules();
		load_parts('{5, 3, 3, 1});
		send_item(ydc_pkg::OP_DEL, 7'd1, 1'b0);
		send_item(ydc_pkg::OP_DEL, 7'd2, 1'b0);
		send_item(ydc_pkg::OP_DEL, 7'd0, 1'b0);
		send_item(ydc_pkg::OP_READ, 7'd1, 1'b0);
		load_parts('{2, 2});
		send_item(ydc_pkg::OP_DEL, 7'd0, 1'b0);
		load_parts('{1});
		send_item(ydc_pkg::OP_DEL, 7'd0, 1'b0);
		send_item(ydc_pkg::OP_DEL, 7'd0, 1'b0);
		// pause the sender until the block has answered everything
		drain_results();
	endtask

	task automatic test_random(input int budget);
		int n, top, choice;
		int parts[$];
		while (items_sent < budget) begin
			steady = (items_sent > budget / 2) && (items_sent < budget / 2 + 150);
			choice = $urandom_range(99);
			if (corner_n == 0 || choice < 12) begin
				parts = {};
				n = ($urandom_range(19) == 0) ? $urandom_range(20, ROWS) : $urandom_range(1, 7);
				top = ($urandom_range(9) == 0) ? 127 : $urandom_range(1, 12);
				repeat (n)
					parts.push_back($urandom_range(1, top));
				load_parts(parts);
			end else if (choice < 72) begin
				send_item(ydc_pkg::OP_DEL, 7'($urandom_range(corner_n - 1)), 1'b0);
			end else if (choice < 90) begin
				send_item(ydc_pkg::OP_READ, 7'($urandom_range(corner_n - 1)), 1'b0);
			end else begin
				send_item(2'($urandom_range(3)), 7'($urandom), 1'($urandom));
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid <= 1'b0;
		req.op    <= ydc_pkg::OP_LOAD;
		req.value <= '0;
		req.last  <= 1'b0;
		corner_n = 0;
		part_n = 0;
		error_count = 0;
		items_sent = 0;
		results_seen = 0;
		builds_done = 0;
		deletes_done = 0;
		steady = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_rules();
		test_buffer_full();
		test_bad_index_and_unused();
		test_corner_rules();
		test_random(1150);
		drain_results();

		$display("covered %0d transactions: %0d diagrams built, %0d corner deletions",
			items_sent, builds_done, deletes_done);
		$display("%0d results checked, %0d mismatches", results_seen, error_count);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#40ms;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// File: sim.f
rtl/ydc_pkg.sv
rtl/ydc_if.sv
rtl/ydc_cell.sv
rtl/young_diagram_corner_removal.sv
verif/tb_young_diagram_corner_removal.sv
